FILE: rtl/rns_gadget_digit_decompose_core_assert.svh
// assertion macros shared by the rtl files
`ifndef RNS_GADGET_DIGIT_DECOMPOSE_CORE_ASSERT_SVH
`define RNS_GADGET_DIGIT_DECOMPOSE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RGDD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RGDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rgdd_pkg.sv
`timescale 1ns / 1ps
package rgdd_pkg;
	localparam int DATA_W       = 64;
	localparam int MOD_W        = 60;
	localparam int DIGIT_W      = 32;
	localparam int CNT_W        = 7;
	localparam int POS_W        = 6;
	localparam int RES_W        = 2;
	localparam int NUM_RESIDUES = 4;
	localparam int MAX_DIGITS   = 64;
	localparam int MIN_BASE     = 2;
	localparam int ITER_W       = 7;
	localparam int ADDR_W       = 6;
	localparam int PDATA_W      = 64;
	localparam int REG_IDX_W    = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MOD0  = 3'd0,
		REG_MOD1  = 3'd1,
		REG_MOD2  = 3'd2,
		REG_MOD3  = 3'd3,
		REG_BASE  = 3'd4,
		REG_COUNT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [NUM_RESIDUES-1:0][MOD_W-1:0] modulus;
		logic [DIGIT_W-1:0]                 base;
		logic [CNT_W-1:0]                   count;
	} cfg_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;
endpackage

FILE: rtl/rgdd_regs.sv
`timescale 1ns / 1ps
module rgdd_regs
	import rgdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);
	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RESIDUES; i++) begin
				cfg_q.modulus[i] <= {MOD_W{1'b1}};
			end
			cfg_q.base  <= DIGIT_W'(MIN_BASE);
			cfg_q.count <= CNT_W'(1);
		end else if (wr_en) begin
			unique case (idx)
				REG_MOD0:  cfg_q.modulus[0] <= pwdata[MOD_W-1:0];
				REG_MOD1:  cfg_q.modulus[1] <= pwdata[MOD_W-1:0];
				REG_MOD2:  cfg_q.modulus[2] <= pwdata[MOD_W-1:0];
				REG_MOD3:  cfg_q.modulus[3] <= pwdata[MOD_W-1:0];
				REG_BASE:  cfg_q.base       <= pwdata[DIGIT_W-1:0];
				REG_COUNT: cfg_q.count      <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MOD0:  prdata = PDATA_W'(cfg_q.modulus[0]);
			REG_MOD1:  prdata = PDATA_W'(cfg_q.modulus[1]);
			REG_MOD2:  prdata = PDATA_W'(cfg_q.modulus[2]);
			REG_MOD3:  prdata = PDATA_W'(cfg_q.modulus[3]);
			REG_BASE:  prdata = PDATA_W'(cfg_q.base);
			REG_COUNT: prdata = PDATA_W'(cfg_q.count);
			default:   prdata = '0;
		endcase
	end
endmodule

FILE: rtl/rgdd_divider.sv
`timescale 1ns / 1ps
`include "rns_gadget_digit_decompose_core_assert.svh"
module rgdd_divider
	import rgdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          ctl,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output div_sts_t          sts,
	output logic [DATA_W-1:0] quotient,
	output logic [DATA_W-1:0] remainder
);
	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W:0]   rem_shift;
	logic [DATA_W:0]   rem_diff;
	logic              fits;

	// one restoring step per cycle
	assign rem_shift = {rem_q, quo_q[DATA_W-1]};
	assign rem_diff  = rem_shift - {1'b0, dsr_q};
	assign fits      = rem_shift >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DATA_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DATA_W-2:0], fits};
			rem_q <= fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`RGDD_ASSERT_NEXT(a_start_busy, ctl.start, busy_q, "divider not busy after start")
	`RGDD_ASSERT_NOW(a_done_after_busy, done_q, $past(busy_q) && !busy_q, "done without run")
	`RGDD_ASSERT_NOW(a_rem_below, done_q, rem_q < dsr_q, "remainder not below divisor")
endmodule

FILE: rtl/rns_gadget_digit_decompose_core.sv
`timescale 1ns / 1ps
`include "rns_gadget_digit_decompose_core_assert.svh"
// Gadget digit decomposition of one RNS coefficient. A request carries a
// coefficient and its residue index; the coefficient is reduced modulo that
// residue's modulus and then split into digit_count base digits, least
// significant first, the last one flagged. All division runs on one shared
// restoring divider that retires one quotient bit per cycle while busy. The
// reduction is skipped when the modulus is zero; each digit of a nonzero value
// takes one division and then a move into the output register, and each digit
// once the value is zero takes no division; a stalled output holds the run. The
// block takes no new request until the last digit of the current one has
// entered the output register. Registers sit at byte address 8*i on a 64-bit
// APB port: moduli 0..3, digit_base, digit_count.
module rns_gadget_digit_decompose_core
	import rgdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [RES_W-1:0]   residue_index,
	input  logic [DATA_W-1:0]  coefficient,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DIGIT_W-1:0] digit,
	output logic [POS_W-1:0]   digit_position,
	output logic               last_digit
);
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REDUCE = 4'b0010,
		ST_DIVIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	cfg_t               cfg;
	div_ctl_t           div_ctl;
	div_sts_t           div_sts;
	logic [DATA_W-1:0]  div_dividend;
	logic [DATA_W-1:0]  div_divisor;
	logic [DATA_W-1:0]  div_quo;
	logic [DATA_W-1:0]  div_rem;

	state_t             state_q;
	logic [DATA_W-1:0]  value_q;
	logic [DIGIT_W-1:0] base_q;
	logic [POS_W-1:0]   last_pos_q;
	logic [POS_W-1:0]   pos_q;
	logic [DIGIT_W-1:0] pend_q;
	logic               out_valid_q;
	logic [DIGIT_W-1:0] digit_q;
	logic [POS_W-1:0]   digit_pos_q;
	logic               last_q;

	logic               in_acc;
	logic [RES_W-1:0]   sel;
	logic [MOD_W-1:0]   mod_sel;
	logic [DIGIT_W-1:0] base_eff;
	logic [CNT_W-1:0]   cnt_eff;
	logic [CNT_W-1:0]   cnt_last;
	logic               slot_free;
	logic               emit_now;
	logic               launch;

	rgdd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rgdd_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign sel       = (32'(residue_index) < NUM_RESIDUES) ? residue_index : '0;
	assign mod_sel   = cfg.modulus[sel];
	assign base_eff  = (cfg.base < DIGIT_W'(MIN_BASE)) ? DIGIT_W'(MIN_BASE) : cfg.base;
	assign cnt_eff   = (cfg.count == '0) ? CNT_W'(1) :
	                   (cfg.count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : cfg.count;
	assign cnt_last  = cnt_eff - CNT_W'(1);
	assign slot_free = ~out_valid_q | ~out_stall;
	assign emit_now  = (state_q == ST_EMIT) && slot_free;

	// next digit launch once the current one has left for the output register
	assign launch = emit_now && (pos_q != last_pos_q) && (value_q != '0);

	always_comb begin
		div_ctl.start = 1'b0;
		div_dividend  = value_q;
		div_divisor   = DATA_W'(base_q);
		unique case (state_q)
			ST_IDLE: begin
				div_dividend  = coefficient;
				div_divisor   = (mod_sel != '0) ? DATA_W'(mod_sel) : DATA_W'(base_eff);
				div_ctl.start = in_acc && ((mod_sel != '0) || (coefficient != '0));
			end
			ST_REDUCE: begin
				div_dividend  = div_rem;
				div_ctl.start = div_sts.done && (div_rem != '0);
			end
			ST_EMIT: begin
				div_ctl.start = launch;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (mod_sel != '0) ? ST_REDUCE :
						           (coefficient != '0) ? ST_DIVIDE : ST_EMIT;
					end
				end
				ST_REDUCE: begin
					if (div_sts.done) begin
						state_q <= (div_rem != '0) ? ST_DIVIDE : ST_EMIT;
					end
				end
				ST_DIVIDE: begin
					if (div_sts.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_now) begin
						if (pos_q == last_pos_q) begin
							state_q <= ST_IDLE;
						end else if (value_q != '0) begin
							state_q <= ST_DIVIDE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digit computation: the emit state holds the digit in pend_q
	always_ff @(posedge clk) begin
		if (in_acc) begin
			base_q     <= base_eff;
			last_pos_q <= cnt_last[POS_W-1:0];
			pos_q      <= '0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					value_q <= coefficient;
					pend_q  <= '0;
				end
			end
			ST_REDUCE: begin
				if (div_sts.done) begin
					value_q <= div_rem;
					pend_q  <= '0;
				end
			end
			ST_DIVIDE: begin
				if (div_sts.done) begin
					pend_q  <= div_rem[DIGIT_W-1:0];
					value_q <= div_quo;
				end
			end
			ST_EMIT: begin
				if (emit_now) begin
					digit_q     <= pend_q;
					digit_pos_q <= pos_q;
					last_q      <= (pos_q == last_pos_q);
					pos_q       <= pos_q + POS_W'(1);
					// value used up, remaining digits are zero
					if (value_q == '0) begin
						pend_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign digit          = digit_q;
	assign digit_position = digit_pos_q;
	assign last_digit     = last_q;

	`RGDD_ASSERT_NOW(a_accept_idle, in_acc, state_q == ST_IDLE && !div_sts.busy,
		"request taken while busy")
	`RGDD_ASSERT_NOW(a_done_state, div_sts.done,
		state_q == ST_REDUCE || state_q == ST_DIVIDE, "divider done in wrong state")
	`RGDD_ASSERT_NEXT(a_emit_loads, state_q == ST_EMIT && !out_valid_q, out_valid_q,
		"free output slot not filled")
	`RGDD_ASSERT_NOW(a_last_pos, out_valid_q && last_q, digit_pos_q == last_pos_q,
		"last digit at wrong position")
endmodule
